FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the amplifier supervisor top-level rtl file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define APSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define APSM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/apsm_pkg.sv
// ----------------------------------------------------------------------------
// apsm_pkg
// Types, codes and widths shared by the amplifier supervisor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package apsm_pkg;

  localparam int TEMP_W = 16;
  localparam int THR_W = 16;
  localparam int CMP_W = (TEMP_W > THR_W) ? TEMP_W : THR_W;

  // beat layouts
  localparam int CMD_W = 3;
  localparam int S_BITS = 7 + TEMP_W;
  localparam int S_DATA_W = ((S_BITS + 7) / 8) * 8;
  localparam int M_BITS = 14 + TEMP_W;
  localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = THR_W;

  localparam logic signed [THR_W-1:0] WARN_RESET = THR_W'(1280);
  localparam logic signed [THR_W-1:0] SHUT_RESET = THR_W'(1520);

  typedef logic signed [CMP_W-1:0] cmp_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 3'd0,
    CMD_STOP   = 3'd1,
    CMD_MUTE   = 3'd2,
    CMD_UNMUTE = 3'd3,
    CMD_POLL   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_OFF        = 3'd0,
    MODE_STARTING   = 3'd1,
    MODE_READY      = 3'd2,
    MODE_MUTED      = 3'd3,
    MODE_PROTECTION = 3'd4,
    MODE_OVERHEATED = 3'd5,
    MODE_FAULT      = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_DENIED    = 2'd1,
    STAT_MUTE_ERR  = 2'd2,
    STAT_TEMP_ERR  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WARN   = 2'd0,
    REG_SHUT   = 2'd1,
    REG_EVENTS = 2'd2
  } reg_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic                     power_on_ok;
    logic                     mute_line_ok;
    logic                     flags_valid;
    logic                     fault_flag;
    logic                     protection_flag;
    logic                     clipping_flag;
    logic                     temp_valid;
    logic signed [TEMP_W-1:0] temperature;
  } item_t;

  typedef struct packed {
    mode_e mode;
    logic  warned;
    logic  no_amp_hw;
    logic  mute_level;
    logic  power_level;
  } state_t;

  typedef struct packed {
    logic signed [THR_W-1:0] warn_threshold;
    logic signed [THR_W-1:0] shutdown_threshold;
    logic                    events_enabled;
  } cfg_t;

  typedef struct packed {
    status_e                  status;
    mode_e                    amp_state;
    logic                     mute_line;
    logic                     power_line;
    logic                     dac_direct;
    logic                     healthy;
    logic                     evt_fault;
    logic                     evt_protection;
    logic                     evt_clipping;
    logic                     evt_overheat;
    logic                     evt_temp_warning;
    logic signed [TEMP_W-1:0] temperature_out;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/amp_protection_state_machine.sv
// ----------------------------------------------------------------------------
// amp_protection_state_machine
// Amplifier supervisor: start, stop, mute, unmute and poll commands drive a
// seven-state amplifier state with thermal and fault protection.
// ----------------------------------------------------------------------------
// One command beat is accepted every clock while the result side keeps taking
// its beats. An accepted beat is held in the input register, and the
// supervisor state and the result register are updated from it when it
// advances, so its result beat is presented from the result register. The rate
// of one beat per clock is set by the state update loop, a single pass of
// compares and selection through the core logic. When the result side holds
// off, the input register keeps its beat and s_tready drops once it is full.
// Configuration writes are always accepted and take effect on the following
// cycle; change them only while no beat is in flight.
`default_nettype none
`include "assert_macros.svh"

module amp_protection_state_machine (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // command beats
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // power_on_ok, mute_line_ok, flags_valid, fault_flag, protection_flag,
  // clipping_flag, temp_valid, temperature, zero pad
  input  wire logic [apsm_pkg::S_DATA_W-1:0]   s_tdata,
  // cmd
  input  wire logic [apsm_pkg::CMD_W-1:0]      s_tuser,
  // result beats
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // status, amp_state, mute_line, power_line, dac_direct, healthy, evt_fault,
  // evt_protection, evt_clipping, evt_overheat, evt_temp_warning,
  // temperature_out, zero pad
  output logic [apsm_pkg::M_DATA_W-1:0]        m_tdata,
  // register writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [apsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [apsm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import apsm_pkg::*;

  cfg_t    cfg;
  item_t   item_in;
  item_t   item;
  logic    in_valid;
  logic    advance;
  state_t  st;
  state_t  st_next;
  result_t res;

  apsm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign item_in.cmd             = cmd_e'(s_tuser);
  assign item_in.power_on_ok     = s_tdata[0];
  assign item_in.mute_line_ok    = s_tdata[1];
  assign item_in.flags_valid     = s_tdata[2];
  assign item_in.fault_flag      = s_tdata[3];
  assign item_in.protection_flag = s_tdata[4];
  assign item_in.clipping_flag   = s_tdata[5];
  assign item_in.temp_valid      = s_tdata[6];
  assign item_in.temperature     = s_tdata[7 +: TEMP_W];

  // input register moves on when the result register is free or draining
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item <= item_in;
    end
  end

  apsm_core u_core (
    .item    (item),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode        <= MODE_OFF;
      st.warned      <= 1'b0;
      st.no_amp_hw   <= 1'b0;
      st.mute_level  <= 1'b0;
      st.power_level <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // status in the lowest bits, temperature_out on top
  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= M_DATA_W'({res.temperature_out, res.evt_temp_warning, res.evt_overheat,
                            res.evt_clipping, res.evt_protection, res.evt_fault,
                            res.healthy, res.dac_direct, res.power_line, res.mute_line,
                            res.amp_state, res.status});
    end
  end

  // dac-direct is never left once entered
  `APSM_ASSERT(a_dac_sticky, st.no_amp_hw |=> st.no_amp_hw, "dac-direct flag cleared")
  // every item that leaves the input register shows up as a result beat
  `APSM_ASSERT(a_advance_out, advance |=> m_tvalid, "result beat lost")
  // a pending item never overtakes a result beat that is still held
  `APSM_ASSERT(a_no_overwrite, m_tvalid && !m_tready |-> !advance,
    "result beat overwritten")
  // event pulses only leave while events are enabled
  `APSM_ASSERT(a_evt_gate,
    advance && !cfg.events_enabled |=>
      m_tdata[13:9] == 5'b00000,
    "event pulse with events disabled")
  `APSM_ASSERT_ALWAYS(a_rst_idle, rst |=> !m_tvalid && !in_valid,
    "beats held across reset")

endmodule

`default_nettype wire

FILE: rtl/apsm_cfg.sv
// ----------------------------------------------------------------------------
// apsm_cfg
// Threshold and event enable registers, written over the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module apsm_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [apsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [apsm_pkg::CFG_DATA_W-1:0] cfg_data,
  output apsm_pkg::cfg_t                      cfg
);
  import apsm_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warn_threshold     <= WARN_RESET;
      cfg.shutdown_threshold <= SHUT_RESET;
      cfg.events_enabled     <= 1'b1;
    end else if (cfg_valid) begin
      case (reg_e'(cfg_index))
        REG_WARN:   cfg.warn_threshold     <= THR_W'(cfg_data);
        REG_SHUT:   cfg.shutdown_threshold <= THR_W'(cfg_data);
        REG_EVENTS: cfg.events_enabled     <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/apsm_core.sv
// ----------------------------------------------------------------------------
// apsm_core
// Next-state and result logic for one command item.
// ----------------------------------------------------------------------------
`default_nettype none

module apsm_core (
  input  apsm_pkg::item_t   item,
  input  apsm_pkg::state_t  st,
  input  apsm_pkg::cfg_t    cfg,
  output apsm_pkg::state_t  st_next,
  output apsm_pkg::result_t res
);
  import apsm_pkg::*;

  logic  poll_live;
  logic  fault_take;
  logic  prot_take;
  mode_e mid_mode;
  logic  mid_mute;
  cmp_t  temp_c;
  logic  over_shut;
  logic  over_warn;
  logic  refused;

  assign poll_live = (item.cmd == CMD_POLL) && !st.no_amp_hw;

  // flag stage of a poll, fault wins over protection
  assign fault_take = item.flags_valid && item.fault_flag && (st.mode != MODE_FAULT);
  assign prot_take  = item.flags_valid && !fault_take && item.protection_flag &&
                      (st.mode != MODE_PROTECTION) && (st.mode != MODE_FAULT);
  assign mid_mode   = fault_take ? MODE_FAULT : (prot_take ? MODE_PROTECTION : st.mode);
  assign mid_mute   = st.mute_level | fault_take | prot_take;

  assign temp_c    = cmp_t'(item.temperature);
  assign over_shut = temp_c >= cmp_t'(cfg.shutdown_threshold);
  assign over_warn = temp_c >= cmp_t'(cfg.warn_threshold);
  assign refused   = st.mode inside {MODE_FAULT, MODE_OVERHEATED, MODE_PROTECTION};

  always_comb begin
    st_next = st;
    case (item.cmd)
      CMD_START: begin
        if (!item.power_on_ok) begin
          st_next.no_amp_hw = 1'b1;
          st_next.mode      = MODE_READY;
        end else begin
          st_next.power_level = 1'b1;
          st_next.mute_level  = 1'b1;
          st_next.mode        = MODE_STARTING;
        end
      end
      CMD_STOP: begin
        if (!st.no_amp_hw) begin
          st_next.mute_level  = 1'b1;
          st_next.power_level = 1'b0;
        end
        st_next.mode = MODE_OFF;
      end
      CMD_MUTE: begin
        if (!st.no_amp_hw && item.mute_line_ok) begin
          st_next.mute_level = 1'b1;
          if (st.mode inside {MODE_READY, MODE_STARTING}) begin
            st_next.mode = MODE_MUTED;
          end
        end
      end
      CMD_UNMUTE: begin
        if (!st.no_amp_hw && !refused && item.mute_line_ok) begin
          st_next.mute_level = 1'b0;
          st_next.mode       = MODE_READY;
        end
      end
      CMD_POLL: begin
        if (!st.no_amp_hw) begin
          st_next.mode       = mid_mode;
          st_next.mute_level = mid_mute;
          if (item.temp_valid) begin
            if (over_shut) begin
              if (mid_mode != MODE_OVERHEATED) begin
                st_next.mute_level = 1'b1;
                st_next.mode       = MODE_OVERHEATED;
              end
            end else if (over_warn) begin
              st_next.warned = 1'b1;
            end else begin
              st_next.warned = 1'b0;
              if (mid_mode == MODE_OVERHEATED) begin
                st_next.mode = MODE_MUTED;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.status = STAT_OK;
    case (item.cmd)
      CMD_MUTE: begin
        if (!st.no_amp_hw && !item.mute_line_ok) begin
          res.status = STAT_MUTE_ERR;
        end
      end
      CMD_UNMUTE: begin
        if (!st.no_amp_hw) begin
          if (refused) begin
            res.status = STAT_DENIED;
          end else if (!item.mute_line_ok) begin
            res.status = STAT_MUTE_ERR;
          end
        end
      end
      CMD_POLL: begin
        if (!st.no_amp_hw && !item.temp_valid) begin
          res.status = STAT_TEMP_ERR;
        end
      end
      default: ;
    endcase

    res.amp_state  = st_next.mode;
    res.mute_line  = st_next.mute_level;
    res.power_line = st_next.power_level;
    res.dac_direct = st_next.no_amp_hw;
    res.healthy    = st_next.mode != MODE_FAULT;

    res.evt_fault        = cfg.events_enabled && poll_live && fault_take;
    res.evt_protection   = cfg.events_enabled && poll_live && prot_take;
    res.evt_clipping     = cfg.events_enabled && poll_live && item.flags_valid &&
                           item.clipping_flag;
    res.evt_overheat     = cfg.events_enabled && poll_live && item.temp_valid &&
                           over_shut && (mid_mode != MODE_OVERHEATED);
    res.evt_temp_warning = cfg.events_enabled && poll_live && item.temp_valid &&
                           !over_shut && over_warn && !st.warned;

    res.temperature_out = (poll_live && item.temp_valid) ? item.temperature : '0;
  end

endmodule

`default_nettype wire

FILE: tb/amp_protection_state_machine_tb.sv
// ----------------------------------------------------------------------------
// amp_protection_state_machine_tb
// Self-checking bench for the amplifier supervisor. Command beats are driven
// on the slave side and every result beat is checked, field by field, against
// a behavioural copy of the supervisor kept in the bench, or against the fixed
// result a bring-up row carries. A short bring-up script runs first. Random
// phases follow, each with its own threshold setting and one of four back-pressure
// patterns. DAC-direct mode is sticky, so it is exercised only at the end of the run.
// ----------------------------------------------------------------------------
module amp_protection_state_machine_tb;
  import apsm_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS = 200;
  localparam int DAC_ITEMS = 60;
  localparam int N_FIELDS = 12;

  // command codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI  = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic                     power_ok;
    logic                     line_ok;
    logic                     flags_ok;
    logic                     fault;
    logic                     prot;
    logic                     clip;
    logic                     temp_ok;
    logic signed [TEMP_W-1:0] temp;
  } beat_t;

  typedef struct packed {
    beat_t   stim;
    logic    typed;
    result_t want;
  } row_t;

  // result fields from the lowest bit of m_tdata up
  localparam int FIELD_LSB [N_FIELDS] = '{0, 2, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14};
  localparam int FIELD_W [N_FIELDS] = '{2, 3, 1, 1, 1, 1, 1, 1, 1, 1, 1, TEMP_W};
  string field_name [N_FIELDS] = '{"status", "amp_state", "mute_line", "power_line",
    "dac_direct", "healthy", "evt_fault", "evt_protection", "evt_clipping",
    "evt_overheat", "evt_temp_warning", "temperature_out"};

  localparam result_t NONE = '0;
  localparam result_t R_OFF = '{STAT_OK, MODE_OFF, 0, 0, 0, 1, 0, 0, 0, 0, 0, 16'sd0};
  localparam result_t R_OFF_LINE_ERR =
    '{STAT_MUTE_ERR, MODE_OFF, 0, 0, 0, 1, 0, 0, 0, 0, 0, 16'sd0};
  localparam result_t R_STARTING =
    '{STAT_OK, MODE_STARTING, 1, 1, 0, 1, 0, 0, 0, 0, 0, 16'sd0};
  localparam result_t R_STARTING_TEMP_ERR =
    '{STAT_TEMP_ERR, MODE_STARTING, 1, 1, 0, 1, 0, 0, 0, 0, 0, 16'sd0};
  localparam result_t R_HOT_DENIED =
    '{STAT_DENIED, MODE_OVERHEATED, 1, 1, 0, 1, 0, 0, 0, 0, 0, 16'sd0};
  localparam result_t R_FAULT_DENIED =
    '{STAT_DENIED, MODE_FAULT, 1, 1, 0, 0, 0, 0, 0, 0, 0, 16'sd0};

  // cmd, power_ok, line_ok, flags_ok, fault, prot, clip, temp_ok, temp
  localparam int N_OPENING = 25;
  row_t opening_rows [N_OPENING] = '{
    '{'{CMD_POLL,       0, 0, 1, 0, 0, 0, 1, 16'sd0},    1, R_OFF},
    '{'{CMD_UNMUTE,     0, 0, 0, 0, 0, 0, 0, 16'sd0},    1, R_OFF_LINE_ERR},
    '{'{CMD_MUTE,       0, 0, 0, 0, 0, 0, 0, 16'sd0},    1, R_OFF_LINE_ERR},
    '{'{CMD_START,      1, 0, 0, 0, 0, 0, 0, 16'sd0},    1, R_STARTING},
    '{'{CMD_POLL,       0, 0, 1, 0, 0, 0, 0, 16'sd0},    1, R_STARTING_TEMP_ERR},
    '{'{CMD_MUTE,       0, 1, 0, 0, 0, 0, 0, 16'sd0},    0, NONE},
    '{'{CMD_UNMUTE,     0, 1, 0, 0, 0, 0, 0, 16'sd0},    0, NONE},
    '{'{CMD_POLL,       0, 0, 1, 0, 0, 1, 1, 16'sd1280}, 0, NONE},
    '{'{CMD_POLL,       0, 0, 1, 0, 0, 0, 1, 16'sd1519}, 0, NONE},
    '{'{CMD_POLL,       0, 0, 1, 0, 0, 0, 1, 16'sh7fff}, 0, NONE},
    '{'{CMD_UNMUTE,     0, 1, 0, 0, 0, 0, 0, 16'sd0},    1, R_HOT_DENIED},
    '{'{CMD_POLL,       0, 0, 1, 0, 0, 0, 1, 16'sd1279}, 0, NONE},
    '{'{CMD_POLL,       0, 0, 1, 1, 1, 0, 0, 16'sd0},    0, NONE},
    '{'{CMD_UNMUTE,     0, 1, 0, 0, 0, 0, 0, 16'sd0},    1, R_FAULT_DENIED},
    '{'{CMD_POLL,       0, 0, 1, 0, 1, 0, 1, 16'sh8000}, 0, NONE},
    '{'{CMD_POLL,       0, 0, 1, 1, 0, 0, 1, 16'sd1520}, 0, NONE},
    '{'{CMD_POLL,       0, 0, 1, 0, 0, 0, 1, 16'sd1000}, 0, NONE},
    '{'{CMD_POLL,       0, 0, 1, 0, 1, 0, 1, 16'sd0},    0, NONE},
    '{'{CMD_UNMUTE,     0, 1, 0, 0, 0, 0, 0, 16'sd0},    0, NONE},
    '{'{CMD_POLL,       0, 0, 0, 1, 1, 1, 1, 16'sd0},    0, NONE},
    '{'{CMD_MUTE,       0, 1, 0, 0, 0, 0, 0, 16'sd0},    0, NONE},
    '{'{CMD_STOP,       0, 0, 0, 0, 0, 0, 0, 16'sd0},    0, NONE},
    '{'{CMD_UNUSED_LO,  1, 1, 1, 1, 1, 1, 1, 16'sh7fff}, 0, NONE},
    '{'{CMD_UNUSED_MID, 0, 0, 1, 1, 0, 0, 1, 16'sd2000}, 0, NONE},
    '{'{CMD_UNUSED_HI,  1, 1, 1, 1, 1, 1, 1, 16'sh8000}, 0, NONE}
  };

  // failed power-on, then every command with no amplifier to drive
  localparam int N_DAC = 6;
  row_t dac_rows [N_DAC] = '{
    '{'{CMD_START,  0, 0, 0, 0, 0, 0, 0, 16'sd0},    0, NONE},
    '{'{CMD_MUTE,   0, 0, 0, 0, 0, 0, 0, 16'sd0},    0, NONE},
    '{'{CMD_UNMUTE, 0, 0, 0, 0, 0, 0, 0, 16'sd0},    0, NONE},
    '{'{CMD_POLL,   0, 0, 1, 1, 1, 1, 1, 16'sh7fff}, 0, NONE},
    '{'{CMD_STOP,   0, 0, 0, 0, 0, 0, 0, 16'sd0},    0, NONE},
    '{'{CMD_START,  1, 0, 0, 0, 0, 0, 0, 16'sd0},    0, NONE}
  };

  localparam logic signed [THR_W-1:0] PHASE_WARN [8] =
    '{16'sd1280, 16'sh8000, 16'sh7fff, 16'sd100, 16'sd0, 16'sd500, 16'sd800, 16'sd0};
  localparam logic signed [THR_W-1:0] PHASE_SHUT [8] =
    '{16'sd1520, 16'sh7fff, 16'sh8000, 16'sd200, 16'sd0, 16'sd500, 16'sd300, 16'sd0};
  localparam logic PHASE_EVENTS [8] = '{1, 1, 0, 1, 0, 1, 1, 1};

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic [CMD_W-1:0]      s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // supervisor state and registers as the bench sees them
  mode_e                   mode_q = MODE_OFF;
  logic                    warned_q = 1'b0;
  logic                    no_hw_q = 1'b0;
  logic                    mute_q = 1'b0;
  logic                    power_q = 1'b0;
  logic signed [THR_W-1:0] warn_thr = WARN_RESET;
  logic signed [THR_W-1:0] shut_thr = SHUT_RESET;
  logic                    events_on = 1'b1;

  row_t    beat_tickets [$];
  result_t results_due [$];
  int      mismatch_count = 0;
  int      quiet_cycles = 0;
  int      tx_idle_pct = 0;
  int      rx_stall_pct = 0;

  amp_protection_state_machine u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic result_t supervise(beat_t b);
    result_t r;
    r = '0;
    r.status = STAT_OK;
    case (b.cmd)
      CMD_START: begin
        if (!b.power_ok) begin
          no_hw_q = 1'b1;
          mode_q = MODE_READY;
        end else begin
          power_q = 1'b1;
          mute_q = 1'b1;
          mode_q = MODE_STARTING;
        end
      end
      CMD_STOP: begin
        if (!no_hw_q) begin
          mute_q = 1'b1;
          power_q = 1'b0;
        end
        mode_q = MODE_OFF;
      end
      CMD_MUTE: begin
        if (!no_hw_q) begin
          if (!b.line_ok) begin
            r.status = STAT_MUTE_ERR;
          end else begin
            mute_q = 1'b1;
            if (mode_q == MODE_READY || mode_q == MODE_STARTING) mode_q = MODE_MUTED;
          end
        end
      end
      CMD_UNMUTE: begin
        if (!no_hw_q) begin
          if (mode_q inside {MODE_FAULT, MODE_OVERHEATED, MODE_PROTECTION}) begin
            r.status = STAT_DENIED;
          end else if (!b.line_ok) begin
            r.status = STAT_MUTE_ERR;
          end else begin
            mute_q = 1'b0;
            mode_q = MODE_READY;
          end
        end
      end
      CMD_POLL: begin
        if (!no_hw_q) begin
          if (b.flags_ok) begin
            // fault wins over protection
            if (b.fault && mode_q != MODE_FAULT) begin
              mute_q = 1'b1;
              mode_q = MODE_FAULT;
              r.evt_fault = 1'b1;
            end else if (b.prot && mode_q != MODE_PROTECTION && mode_q != MODE_FAULT) begin
              mute_q = 1'b1;
              mode_q = MODE_PROTECTION;
              r.evt_protection = 1'b1;
            end
            r.evt_clipping = b.clip;
          end
          if (!b.temp_ok) begin
            r.status = STAT_TEMP_ERR;
          end else begin
            r.temperature_out = b.temp;
            if (b.temp >= shut_thr) begin
              if (mode_q != MODE_OVERHEATED) begin
                mute_q = 1'b1;
                mode_q = MODE_OVERHEATED;
                r.evt_overheat = 1'b1;
              end
            end else if (b.temp >= warn_thr) begin
              if (!warned_q) begin
                warned_q = 1'b1;
                r.evt_temp_warning = 1'b1;
              end
            end else begin
              warned_q = 1'b0;
              if (mode_q == MODE_OVERHEATED) mode_q = MODE_MUTED;
            end
          end
        end
      end
      default: ;
    endcase
    if (!events_on) begin
      {r.evt_fault, r.evt_protection, r.evt_clipping, r.evt_overheat,
       r.evt_temp_warning} = '0;
    end
    r.amp_state = mode_q;
    r.mute_line = mute_q;
    r.power_line = power_q;
    r.dac_direct = no_hw_q;
    r.healthy = (mode_q != MODE_FAULT);
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    row_t                ticket;
    beat_t               heard;
    result_t             due;
    logic [M_DATA_W-1:0] want_word;
    logic [31:0]         fmask;
    logic                moved;
    moved = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          REG_WARN:   warn_thr = cfg_data;
          REG_SHUT:   shut_thr = cfg_data;
          REG_EVENTS: events_on = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        moved = 1'b1;
        ticket = '0;
        if (beat_tickets.size() != 0) ticket = beat_tickets.pop_front();
        heard = '{s_tuser, s_tdata[0], s_tdata[1], s_tdata[2], s_tdata[3], s_tdata[4],
                  s_tdata[5], s_tdata[6], s_tdata[7 +: TEMP_W]};
        due = supervise(heard);
        if (ticket.typed) due = ticket.want;
        results_due.push_back(due);
      end
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        if (results_due.size() == 0) begin
          $display("%0t: result beat expected none, got %0h", $time, m_tdata);
          mismatch_count++;
        end else begin
          due = results_due.pop_front();
          want_word = M_DATA_W'({due.temperature_out, due.evt_temp_warning, due.evt_overheat,
                                 due.evt_clipping, due.evt_protection, due.evt_fault,
                                 due.healthy, due.dac_direct, due.power_line, due.mute_line,
                                 due.amp_state, due.status});
          for (int f = 0; f < N_FIELDS; f++) begin
            fmask = (32'd1 << FIELD_W[f]) - 32'd1;
            if (((m_tdata >> FIELD_LSB[f]) & fmask) !== ((want_word >> FIELD_LSB[f]) & fmask))
            begin
              $display("%0t: %s expected %0h, got %0h", $time, field_name[f],
                       (want_word >> FIELD_LSB[f]) & fmask, (m_tdata >> FIELD_LSB[f]) & fmask);
              mismatch_count++;
            end
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
    m_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("amp_protection_state_machine regression: fail");
    $finish;
  end

  task automatic send_beat(row_t r);
    beat_tickets.push_back(r);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r.stim.cmd;
    s_tdata <= S_DATA_W'({r.stim.temp, r.stim.temp_ok, r.stim.clip, r.stim.prot,
                          r.stim.fault, r.stim.flags_ok, r.stim.line_ok, r.stim.power_ok});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop sending and let every outstanding result come back
  task automatic hold_off();
    s_tvalid <= 1'b0;
    while (results_due.size() != 0 || beat_tickets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic run_random(int count, logic allow_dac);
    int   done;
    int   sel;
    int   t;
    logic paused;
    row_t r;
    done = 0;
    paused = 1'b0;
    while (done < count) begin
      r = '0;
      sel = $urandom_range(99);
      if (sel < 4) r.stim.cmd = CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
      else if (sel < 14) r.stim.cmd = CMD_START;
      else if (sel < 22) r.stim.cmd = CMD_STOP;
      else if (sel < 34) r.stim.cmd = CMD_MUTE;
      else if (sel < 50) r.stim.cmd = CMD_UNMUTE;
      else r.stim.cmd = CMD_POLL;
      r.stim.power_ok = 1'($urandom_range(1));
      // a failed power-on is sticky until reset, so keep it for the last phase
      if (r.stim.cmd == CMD_START && !allow_dac) r.stim.power_ok = 1'b1;
      r.stim.line_ok = ($urandom_range(9) != 0);
      r.stim.flags_ok = ($urandom_range(7) != 0);
      r.stim.fault = ($urandom_range(15) == 0);
      r.stim.prot = ($urandom_range(7) == 0);
      r.stim.clip = 1'($urandom_range(1));
      r.stim.temp_ok = ($urandom_range(11) != 0);
      // mostly close to the thresholds, where the thermal decisions flip
      case ($urandom_range(9))
        0:       t = $urandom;
        1, 2:    t = int'(warn_thr) + $urandom_range(4) - 2;
        3, 4:    t = int'(shut_thr) + $urandom_range(4) - 2;
        5:       t = $urandom_range(1) ? 32767 : -32768;
        default: t = int'(warn_thr) - $urandom_range(300) + $urandom_range(60);
      endcase
      r.stim.temp = t[TEMP_W-1:0];
      if (!paused && done >= count / 2) begin
        paused = 1'b1;
        hold_off();
      end
      send_beat(r);
      if (r.stim.cmd < CMD_UNUSED_LO) done++;
    end
  endtask

  initial begin : stimulus
    logic signed [THR_W-1:0] warn_set;
    logic signed [THR_W-1:0] shut_set;
    logic                    ev_set;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (opening_rows[i]) send_beat(opening_rows[i]);
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 79; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 79; end
        default: begin tx_idle_pct = 31; rx_stall_pct = 31; end
      endcase
      if (ph != 0) begin
        warn_set = PHASE_WARN[ph];
        shut_set = PHASE_SHUT[ph];
        ev_set = PHASE_EVENTS[ph];
        if (ph == 4) begin
          warn_set = THR_W'($urandom_range(2000) - 500);
          shut_set = THR_W'(warn_set + $urandom_range(600, 1));
        end else if (ph == 7) begin
          warn_set = THR_W'($urandom);
          shut_set = THR_W'($urandom);
          ev_set = 1'($urandom_range(1));
        end
        hold_off();
        write_reg(REG_WARN, warn_set);
        write_reg(REG_SHUT, shut_set);
        write_reg(REG_EVENTS, CFG_DATA_W'(ev_set));
        cfg_valid <= 1'b0;
      end
      run_random(PHASE_ITEMS, 1'b0);
    end
    hold_off();
    foreach (dac_rows[i]) send_beat(dac_rows[i]);
    run_random(DAC_ITEMS, 1'b1);
    hold_off();
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("amp_protection_state_machine regression: pass");
    end else begin
      $display("amp_protection_state_machine regression: fail");
    end
    $finish;
  end

endmodule
